FILE: sv/sceb_pkg.sv
// sceb_pkg: shared types and constants of the Scharr edge binarizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sceb_pkg;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int FIFO_DEPTH  = 8;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd150;
    localparam logic [PIX_W-1:0] EDGE_ON          = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF         = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

    // win[row][col]: row 0 above the center, col 0 left of it
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        pix_t       pix;
        logic       has_up1;
        logic       has_up2;
        logic       col_zero;
        logic       main_en;
        logic       tail_en;
        logic       eof;
        logic [1:0] nres;
    } stage_t;

    typedef struct packed {
        pix_t edge_value;
        logic eof;
        logic last;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/scharr_edge_binarizer.sv
// scharr_edge_binarizer: streaming 3x3 combined Scharr edge detector, binary output.
// Depends on sceb_pkg, sceb_line_store, sceb_kernel and sceb_out_fifo.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid / in_ready    | req_type, gray_pixel
//   output  | out_valid / out_ready  | edge_value, end_of_frame, last_of_run
//   config  | cfg_we                 | cfg_index, cfg_data
//
// One input word per cycle while in_ready is high; a result passes the line store
// read, window update and kernel registers, then the result queue.
// The row's first pixel gives no result and its last gives two, so each row
// after the first gives as many results as it has pixels.
// in_ready drops only while the result queue lacks room for what is in flight plus two.
// Reset clears counters, window and queue; the line store needs no clearing.
`default_nettype none

module scharr_edge_binarizer
    import sceb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   req_type,
    input  wire logic [PIX_W-1:0]       gray_pixel,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [PIX_W-1:0]            edge_value,
    output logic                        end_of_frame,
    output logic                        last_of_run,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int QW = $clog2(FIFO_DEPTH);

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    pix_t             edge_threshold_reg;

    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;

    logic [WW-1:0]    wdt;
    logic [WW-1:0]    last_col;
    logic [DIM_W-1:0] hgt;
    logic             pad_row;
    logic             end_row;
    logic             accept;
    logic             take;
    stage_t           s0;

    logic             s1_valid_reg;
    stage_t           s1_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s2_valid_reg;
    stage_t           s2_reg;

    logic [2*PIX_W-1:0] rd_data;
    pix_t             up1;
    pix_t             up2;
    win_t             win_reg;
    win_t             win_next;

    logic             push0_valid;
    logic             push1_valid;
    res_t             push0;
    res_t             push1;
    res_t             head;
    logic [QW:0]      q_count;
    logic [QW+2:0]    pending;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg    <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg   <= cfg_data;
                CFG_THRESHOLD:    edge_threshold_reg <= cfg_data[PIX_W-1:0];
                CFG_UNUSED:       ;
            endcase
        end
    end

    // frame geometry and intake
    always_comb
    begin
        if (32'(frame_width_reg) < 32'd3)
            wdt = WW'(3);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            wdt = WW'(MAX_WIDTH);
        else
            wdt = WW'(frame_width_reg);
        last_col = wdt - WW'(1);
        hgt      = (frame_height_reg < DIM_W'(3)) ? DIM_W'(3) : frame_height_reg;
        pad_row  = row_reg >= hgt;
        end_row  = {1'b0, col_reg} >= last_col;
        accept   = in_valid && in_ready;
        take     = accept && (pad_row || !req_type);

        s0.pix      = pad_row ? '0 : gray_pixel;
        s0.has_up1  = row_reg != '0;
        s0.has_up2  = row_reg >= DIM_W'(2);
        s0.col_zero = col_reg == '0;
        s0.main_en  = s0.has_up1 && !s0.col_zero;
        s0.tail_en  = s0.has_up1 && end_row;
        s0.eof      = pad_row;
        s0.nres     = {1'b0, s0.main_en} + {1'b0, s0.tail_en};

        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = pad_row ? '0 : row_reg + DIM_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            win_reg      <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg     <= s0;
        s1_col_reg <= col_reg;
        s2_reg     <= s1_reg;
    end

    sceb_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({rd_data[PIX_W-1:0], s1_reg.pix})
    );

    // window update: shift left (clear at column zero), load the new column
    always_comb
    begin
        up2      = s1_reg.has_up2 ? rd_data[2*PIX_W-1:PIX_W] : '0;
        up1      = s1_reg.has_up1 ? rd_data[PIX_W-1:0] : '0;
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i][0] = s1_reg.col_zero ? '0 : win_reg[i][1];
                win_next[i][1] = s1_reg.col_zero ? '0 : win_reg[i][2];
            end
            win_next[0][2] = up2;
            win_next[1][2] = up1;
            win_next[2][2] = s1_reg.pix;
        end
    end

    sceb_kernel u_kernel (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_en       (s2_valid_reg),
        .flags       (s2_reg),
        .win         (win_reg),
        .threshold   (edge_threshold_reg),
        .push0_valid (push0_valid),
        .push0       (push0),
        .push1_valid (push1_valid),
        .push1       (push1)
    );

    sceb_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push0_valid (push0_valid),
        .push0       (push0),
        .push1_valid (push1_valid),
        .push1       (push1),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .head        (head),
        .count       (q_count)
    );

    // reserve queue room for every word still in flight
    always_comb
    begin
        pending = (QW+3)'(q_count)
                + (s1_valid_reg ? (QW+3)'(s1_reg.nres) : '0)
                + (s2_valid_reg ? (QW+3)'(s2_reg.nres) : '0)
                + (QW+3)'(push0_valid) + (QW+3)'(push1_valid);
        in_ready = pending <= (QW+3)'(FIFO_DEPTH - 2);
    end

    assign edge_value   = head.edge_value;
    assign end_of_frame = head.eof;
    assign last_of_run  = head.last;

    a_no_addr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_valid_reg) |-> (col_reg != s1_col_reg))
        else $error("line store read and write hit the same column");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending) <= FIFO_DEPTH)
        else $error("in-flight words exceed queue depth");

    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> last_of_run)
        else $error("end of frame word not last of its run");

endmodule

`default_nettype wire

FILE: sv/sceb_line_store.sv
// sceb_line_store: line store RAM, one entry per column holding {older, newer} row.
// One write and one read port, read data registered; uses sceb_pkg.
`default_nettype none

module sceb_line_store
    import sceb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [2*PIX_W-1:0]       rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [2*PIX_W-1:0]       wr_data
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/sceb_kernel.sv
// sceb_kernel: combined Scharr mask, absolute value, clamp and threshold.
// Registers up to two results per window; uses sceb_pkg.
`default_nettype none

module sceb_kernel
    import sceb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_en,
    input  wire stage_t flags,
    input  wire win_t   win,
    input  wire pix_t   threshold,
    output logic        push0_valid,
    output res_t        push0,
    output logic        push1_valid,
    output res_t        push1
);

    function automatic pix_t edge_bin(input pix_t p6, input pix_t p10a, input pix_t p10b,
                                      input pix_t n6, input pix_t n10a, input pix_t n10b,
                                      input pix_t thr);
        logic signed [15:0] pos;
        logic signed [15:0] neg;
        logic signed [15:0] sum;
        logic        [15:0] mag;
        pix_t               clamped;
        pos = 16'sd6 * $signed({8'd0, p6}) + 16'sd10 * $signed({8'd0, p10a})
            + 16'sd10 * $signed({8'd0, p10b});
        neg = 16'sd6 * $signed({8'd0, n6}) + 16'sd10 * $signed({8'd0, n10a})
            + 16'sd10 * $signed({8'd0, n10b});
        sum = pos - neg;
        mag = (sum < 16'sd0) ? 16'(-sum) : 16'(sum);
        clamped = (mag > 16'd255) ? 8'd255 : mag[7:0];
        return (clamped >= thr) ? EDGE_ON : EDGE_OFF;
    endfunction

    pix_t main_value;
    pix_t tail_value;
    res_t main_res;
    res_t tail_res;

    logic push0_valid_reg;
    logic push1_valid_reg;
    res_t push0_reg;
    res_t push1_reg;

    always_comb
    begin
        main_value = edge_bin(win[0][0], win[0][1], win[1][0],
                              win[2][2], win[1][2], win[2][1], threshold);
        tail_value = edge_bin(win[0][1], win[0][2], win[1][1],
                              EDGE_OFF, win[2][2], EDGE_OFF, threshold);
        main_res.edge_value = main_value;
        main_res.eof        = 1'b0;
        main_res.last       = !flags.tail_en;
        tail_res.edge_value = tail_value;
        tail_res.eof        = flags.eof;
        tail_res.last       = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push0_valid_reg <= 1'b0;
            push1_valid_reg <= 1'b0;
        end
        else
        begin
            push0_valid_reg <= in_en && (flags.main_en || flags.tail_en);
            push1_valid_reg <= in_en && flags.main_en && flags.tail_en;
        end
    end

    always_ff @(posedge clk)
    begin
        push0_reg <= flags.main_en ? main_res : tail_res;
        push1_reg <= tail_res;
    end

    assign push0_valid = push0_valid_reg;
    assign push1_valid = push1_valid_reg;
    assign push0       = push0_reg;
    assign push1       = push1_reg;

endmodule

`default_nettype wire

FILE: sv/sceb_out_fifo.sv
// sceb_out_fifo: result queue taking up to two words a cycle, giving one while out_ready is high.
// Depth from sceb_pkg::FIFO_DEPTH; uses sceb_pkg.
`default_nettype none

module sceb_out_fifo
    import sceb_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push0_valid,
    input  wire res_t                          push0,
    input  wire logic                          push1_valid,
    input  wire res_t                          push1,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output res_t                               head,
    output logic [$clog2(FIFO_DEPTH):0]        count
);

    localparam int AW = $clog2(FIFO_DEPTH);

    res_t            mem_reg [FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;
    logic            pop;
    logic [1:0]      npush;

    assign pop   = out_valid && out_ready;
    assign npush = {1'b0, push0_valid} + {1'b0, push1_valid};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(npush);
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(npush) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0_valid)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push1_valid)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push1;
        end
    end

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(npush)) <= FIFO_DEPTH)
        else $error("result queue overflow");

    a_push1_needs_push0: assert property (@(posedge clk) disable iff (!rst_n)
        push1_valid |-> push0_valid)
        else $error("second word pushed without first");

endmodule

`default_nettype wire

FILE: tb/sv/scharr_edge_binarizer_tb.sv
// scharr_edge_binarizer_tb: self-checking bench for the streaming Scharr edge binarizer.
// Keeps its own copy of the line stores, window and counters to predict every output word.
// Depends on sceb_pkg and scharr_edge_binarizer.
`timescale 1ns / 1ps

module scharr_edge_binarizer_tb;

    import sceb_pkg::*;

    localparam int LINE_MAX       = 1024;
    localparam int GAP_MAX        = 18;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_ITEMS   = 620;

    typedef enum int {
        PIX_NOISE,
        PIX_SMOOTH,
        PIX_BINARY,
        PIX_FLAT
    } pix_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   req_type;
    pix_t                   gray_pixel;
    logic                   out_valid;
    logic                   out_ready;
    pix_t                   edge_value;
    logic                   end_of_frame;
    logic                   last_of_run;
    logic                   cfg_we;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pix_t                   older_line [LINE_MAX];
    pix_t                   newer_line [LINE_MAX];
    win_t                   win_now;
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    pix_t                   thresh_reg;
    res_t                   edge_words [$];

    int                     errors = 0;
    int                     quiet_cycles = 0;
    int                     items_sent = 0;
    int                     pix_base = 0;
    int                     pix_spread = 0;
    bit                     src_calm = 1'b0;
    bit                     sink_calm = 1'b0;

    scharr_edge_binarizer #(
        .MAX_WIDTH (LINE_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .gray_pixel   (gray_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .edge_value   (edge_value),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned clamp_width(input logic [DIM_W-1:0] v);
        if (v < 3)
            return 3;
        if (v > LINE_MAX)
            return LINE_MAX;
        return 32'(v);
    endfunction

    function automatic int unsigned clamp_height(input logic [DIM_W-1:0] v);
        if (v < 3)
            return 3;
        return 32'(v);
    endfunction

    function automatic pix_t edge_of(input win_t p);
        int acc;
        acc = 6 * int'(p[0][0]) + 10 * int'(p[0][1]) + 10 * int'(p[1][0])
            - 10 * int'(p[1][2]) - 10 * int'(p[2][1]) - 6 * int'(p[2][2]);
        if (acc < 0)
            acc = -acc;
        if (acc > 255)
            acc = 255;
        return (acc >= int'(thresh_reg)) ? EDGE_ON : EDGE_OFF;
    endfunction

    task automatic predict_word(input logic kind, input pix_t value);
        int unsigned w, h, c, r, i, n;
        logic        pad_row, end_row;
        pix_t        pix, up2, up1;
        win_t        tail;
        res_t        word [2];
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        pad_row = (row_pos >= h);
        if (!pad_row && kind)
            return;
        pix = pad_row ? '0 : value;
        c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        r = row_pos;
        up2 = (r >= 2) ? older_line[c] : '0;
        up1 = (r >= 1) ? newer_line[c] : '0;
        older_line[c] = newer_line[c];
        newer_line[c] = pix;
        for (i = 0; i < 3; i++)
        begin
            if (c == 0)
            begin
                win_now[i][0] = '0;
                win_now[i][1] = '0;
            end
            else
            begin
                win_now[i][0] = win_now[i][1];
                win_now[i][1] = win_now[i][2];
            end
        end
        win_now[0][2] = up2;
        win_now[1][2] = up1;
        win_now[2][2] = pix;
        end_row = (c >= w - 1);
        n = 0;
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                word[n] = {edge_of(win_now), 1'b0, 1'b0};
                n++;
            end
            if (end_row)
            begin
                for (i = 0; i < 3; i++)
                begin
                    tail[i][0] = win_now[i][1];
                    tail[i][1] = win_now[i][2];
                    tail[i][2] = '0;
                end
                word[n] = {edge_of(tail), pad_row, 1'b0};
                n++;
            end
            if (n > 0)
                word[n - 1].last = 1'b1;
            for (i = 0; i < n; i++)
                edge_words.push_back(word[i]);
        end
        if (end_row)
        begin
            col_pos = 0;
            row_pos = pad_row ? 0 : row_pos + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic report(input string what, input int got, input int want);
        if (errors < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    // track accepted input words and register writes
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    CFG_THRESHOLD:    thresh_reg = cfg_data[PIX_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                predict_word(req_type, gray_pixel);
        end
    end

    always @(posedge clk)
    begin : check_words
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (edge_words.size() == 0)
                report("word with nothing expected", int'(edge_value), -1);
            else
            begin
                want = edge_words.pop_front();
                if (edge_value !== want.edge_value)
                    report("edge_value", int'(edge_value), int'(want.edge_value));
                if (end_of_frame !== want.eof)
                    report("end_of_frame", int'(end_of_frame), int'(want.eof));
                if (last_of_run !== want.last)
                    report("last_of_run", int'(last_of_run), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scharr_edge_binarizer_tb: done, errors");
            $finish;
        end
    end

    // output side: stall a random number of cycles before each word
    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    task automatic send_word(input logic kind, input pix_t value);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        gray_pixel <= value;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, wait until every expected word is out, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (edge_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pix_t draw_pixel(input pix_mode_t mode);
        int v;
        case (mode)
            PIX_SMOOTH:
            begin
                v = pix_base + $urandom_range(0, pix_spread);
                if (v > 255)
                    v = 255;
                return pix_t'(v);
            end
            PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_FLAT:   return pix_t'(pix_base);
            default:    return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input pix_mode_t mode, input int noise_pct);
        int unsigned w, h, r, c;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        pix_base = $urandom_range(0, 255);
        pix_spread = $urandom_range(0, 24);
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_word(1'b1, pix_t'($urandom_range(0, 255)));
                send_word(1'b0, draw_pixel(mode));
            end
        end
        for (c = 0; c < w; c++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(1'b0, pix_t'($urandom_range(0, 255)));
            else
                send_word(1'b1, pix_t'($urandom_range(0, 255)));
        end
        items_sent += (h + 1) * w;
    endtask

    task automatic test_reset_threshold();
        int r, c;
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 3);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_word(1'b0, ((r + c) % 2 == 1) ? 8'hFF : 8'h00);
        repeat (3) send_word(1'b1, 8'hA5);
    endtask

    task automatic test_saturated_registers();
        int r, c;
        settle();
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 2);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_UNUSED, 2047);
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                // stray pad word inside a pixel row
                if (r == 1 && c == 1)
                    send_word(1'b1, 8'hFF);
                send_word(1'b0, (r == 1 && c == 1) ? 8'hFF : pix_t'((r * 3 + c) * 30));
            end
        end
        send_word(1'b1, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b1, 8'h5A);
    endtask

    task automatic test_widest_frame();
        int i;
        settle();
        write_reg(CFG_FRAME_WIDTH, 2047);
        write_reg(CFG_FRAME_HEIGHT, 0);
        write_reg(CFG_THRESHOLD, 255);
        // send one full row at the clamped width, then finish the frame narrow
        for (i = 0; i < LINE_MAX; i++)
            send_word(1'b0, draw_pixel(PIX_NOISE));
        settle();
        write_reg(CFG_FRAME_WIDTH, 3);
        for (i = 0; i < 6; i++)
            send_word(1'b0, draw_pixel(PIX_NOISE));
        repeat (3) send_word(1'b1, 8'h00);
    endtask

    task automatic test_tallest_frame();
        settle();
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 40);
        write_reg(CFG_THRESHOLD, $urandom_range(0, 2047));
        send_frame(pix_mode_t'($urandom_range(0, 3)), 2);
    endtask

    task automatic test_midframe_change();
        int i;
        settle();
        write_reg(CFG_FRAME_WIDTH, 12);
        write_reg(CFG_FRAME_HEIGHT, 8);
        write_reg(CFG_THRESHOLD, $urandom_range(0, 255));
        pix_base = $urandom_range(0, 230);
        pix_spread = $urandom_range(4, 24);
        // three full rows and half of the fourth
        for (i = 0; i < 42; i++)
            send_word(1'b0, draw_pixel(PIX_SMOOTH));
        settle();
        write_reg(CFG_FRAME_WIDTH, 4);
        write_reg(CFG_THRESHOLD, $urandom_range(0, 255));
        send_word(1'b0, draw_pixel(PIX_SMOOTH));
        settle();
        write_reg(CFG_FRAME_HEIGHT, 3);
        repeat (4) send_word(1'b1, pix_t'($urandom_range(0, 255)));
    endtask

    task automatic retune_registers();
        bit do_w, do_h, do_t, do_x;
        do_w = ($urandom_range(0, 1) == 1);
        do_h = ($urandom_range(0, 1) == 1);
        do_t = ($urandom_range(0, 1) == 1);
        do_x = ($urandom_range(0, 7) == 0);
        if (!(do_w || do_h || do_t || do_x))
            return;
        settle();
        if (do_w)
        begin
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_FRAME_WIDTH, $urandom_range(0, 2));
            else if ($urandom_range(0, 7) == 0)
                write_reg(CFG_FRAME_WIDTH, $urandom_range(25, 160));
            else
                write_reg(CFG_FRAME_WIDTH, $urandom_range(3, 24));
        end
        if (do_h)
        begin
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 2));
            else
                write_reg(CFG_FRAME_HEIGHT, $urandom_range(3, 10));
        end
        if (do_t)
            write_reg(CFG_THRESHOLD, $urandom_range(0, 2047));
        if (do_x)
            write_reg(CFG_UNUSED, $urandom_range(0, 2047));
    endtask

    task automatic test_random_frames();
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            retune_registers();
            send_frame(pix_mode_t'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0) ? 8 : 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        gray_pixel = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        win_now = '0;
        col_pos = 0;
        row_pos = 0;
        width_reg = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        thresh_reg = THRESHOLD_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_threshold();
        test_saturated_registers();
        test_widest_frame();
        test_tallest_frame();
        test_midframe_change();
        test_random_frames();

        settle();
        if (edge_words.size() != 0)
            report("words never produced", 0, edge_words.size());
        if (errors == 0)
            $display("scharr_edge_binarizer_tb: done, clean");
        else
            $display("scharr_edge_binarizer_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
sv/sceb_pkg.sv
sv/sceb_line_store.sv
sv/sceb_kernel.sv
sv/sceb_out_fifo.sv
sv/scharr_edge_binarizer.sv
tb/sv/scharr_edge_binarizer_tb.sv
